// ===== rtl/rbpc_pkg.sv =====
package rbpc_pkg;

	localparam int NCNT  = 11;
	localparam int CNT_W = 32;

	localparam logic [3:0] OP_FRAME_START = 4'd0;
	localparam logic [3:0] OP_PASS_START  = 4'd1;
	localparam logic [3:0] OP_PASS_END    = 4'd2;
	localparam logic [3:0] OP_FRAME_END   = 4'd3;
	localparam logic [3:0] OP_SHADER      = 4'd4;
	localparam logic [3:0] OP_MATERIAL    = 4'd5;
	localparam logic [3:0] OP_DRAW        = 4'd6;
	localparam logic [3:0] OP_INSTANCED   = 4'd7;
	localparam logic [3:0] OP_TEXTURE     = 4'd8;
	localparam logic [3:0] OP_PLAIN_DRAW  = 4'd9;
	localparam logic [3:0] OP_READ        = 4'd10;

	localparam int C_DRAW      = 0;
	localparam int C_INST_DRAW = 1;
	localparam int C_INSTANCES = 2;
	localparam int C_SHD_REQ   = 3;
	localparam int C_SHD_CHG   = 4;
	localparam int C_MAT_REQ   = 5;
	localparam int C_MAT_CHG   = 6;
	localparam int C_MESH_REQ  = 7;
	localparam int C_MESH_CHG  = 8;
	localparam int C_TEX_REQ   = 9;
	localparam int C_TEX_CHG   = 10;

	typedef logic [NCNT-1:0] cmask_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TEX,
		S_BUMP_RD,
		S_BUMP_WR,
		S_SWEEP,
		S_READ,
		S_RESP
	} state_t;

	function automatic logic [3:0] first_set(cmask_t m);
		logic [3:0] r;
		r = '0;
		for (int i = NCNT - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/rbpc_alu.sv =====
module rbpc_alu (
	input  rbpc_pkg::cnt_t a,
	input  rbpc_pkg::cnt_t b,
	output rbpc_pkg::cnt_t sum,
	output logic           same
);

	logic [rbpc_pkg::CNT_W:0] wide;

	assign wide = {1'b0, a} + {1'b0, b};
	assign sum  = wide[rbpc_pkg::CNT_W] ? '1 : wide[rbpc_pkg::CNT_W-1:0];
	assign same = (a == b);

endmodule

// ===== rtl/redundant_bind_perf_counters.sv =====
// Per-pass draw and bind counters. Every beat gives one result beat. Pass, frame-start and
// unused operations go straight to the response state, and a snapshot read first reads the
// snapshot store. A record event does one read-modify-write per counter it bumps, after a
// texture table check for an in-range texture unit, through the single counter store port
// and the one shared saturating adder. Frame end walks all PASSES*11 counters through the
// same port and adder, one per cycle, into the snapshot store. The block takes no new beat
// until the previous one is in the output register.
module redundant_bind_perf_counters #(
	parameter int PASSES        = 8,
	parameter int TEXTURE_UNITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  operation,
	input  logic [2:0]  pass_type,
	input  logic [31:0] object_id,
	input  logic [7:0]  texture_unit,
	input  logic        is_cube_map,
	input  logic [23:0] instance_count,
	input  logic [3:0]  counter_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic        snapshot_valid,
	output logic        frame_differed,
	output logic        event_counted
);

	localparam int N   = PASSES * rbpc_pkg::NCNT;
	localparam int AW  = $clog2(N);
	localparam int SAW = AW + 1;
	localparam int TE  = 2 * TEXTURE_UNITS;
	localparam int TEW = $clog2(TE);

	rbpc_pkg::state_t state_q, state_d;

	logic [3:0]   op_q;
	logic [31:0]  id_q;
	logic [23:0]  icount_q;
	logic [TEW-1:0] e_q;

	logic         pass_active_q;
	logic [2:0]   active_pass_q;
	logic [31:0]  last_program_q, last_material_q, last_mesh_q;
	logic [TE-1:0] tex_known_q;
	logic [N-1:0] cur_vld_q, snap_vld_q;
	logic         snap_present_q;
	rbpc_pkg::cmask_t mask_q, mask_acc;
	logic [3:0]   k_q;
	logic [AW-1:0] baddr_q;
	logic         diff_q, counted_q;
	logic [31:0]  rd_q;
	logic [SAW-1:0] sw_addr_q;
	logic         sw_v_s1;
	logic [AW-1:0] sw_a_s1;

	logic         out_valid_q, out_diff_q, out_counted_q, out_snap_q;
	logic [31:0]  out_rd_q;

	rbpc_pkg::cnt_t cur_mem [N];
	rbpc_pkg::cnt_t snap_mem [N];
	logic [31:0]  tex_mem [TE];

	logic         cur_ren, snap_ren;
	logic [AW-1:0] cur_raddr, snap_raddr;
	rbpc_pkg::cnt_t cur_rdata_s1, snap_rdata_s1;
	logic         cur_rvld_s1, snap_rvld_s1;
	logic [31:0]  tex_rdata_s1;

	rbpc_pkg::cnt_t cur_eff, snap_eff, alu_b, alu_sum;
	logic         alu_same;

	logic         acc, ptype_ok, unit_ok, sel_ok, rec_take, tex_chg, resp_go, sw_issue;
	logic [TEW-1:0] e_in;
	logic [3:0]   k_nxt;
	logic [AW-1:0] baddr_nxt, rdaddr_in;

	assign acc      = (state_q == rbpc_pkg::S_IDLE) && in_valid;
	assign in_stall = (state_q != rbpc_pkg::S_IDLE);
	assign ptype_ok = {2'b0, pass_type} < 5'(PASSES);
	assign unit_ok  = {1'b0, texture_unit} < 9'(TEXTURE_UNITS);
	assign sel_ok   = counter_select < 4'(rbpc_pkg::NCNT);
	assign e_in     = TEW'({1'b0, texture_unit, is_cube_map});
	assign rdaddr_in = AW'(int'(pass_type) * rbpc_pkg::NCNT + int'(counter_select));
	assign k_nxt    = rbpc_pkg::first_set(mask_q);
	assign baddr_nxt = AW'(int'(active_pass_q) * rbpc_pkg::NCNT + int'(k_nxt));
	assign cur_eff  = cur_rvld_s1 ? cur_rdata_s1 : '0;
	assign snap_eff = snap_rvld_s1 ? snap_rdata_s1 : '0;
	assign tex_chg  = !tex_known_q[e_q] || (tex_rdata_s1 != id_q);
	assign resp_go  = !out_valid_q || !out_stall;
	assign sw_issue = sw_addr_q < SAW'(N);

	always_comb begin
		alu_b = 32'd1;
		if (state_q == rbpc_pkg::S_SWEEP) begin
			alu_b = snap_eff;
		end else if (k_q == 4'(rbpc_pkg::C_INSTANCES) && op_q == rbpc_pkg::OP_INSTANCED) begin
			alu_b = 32'(icount_q);
		end
	end

	rbpc_alu u_alu (
		.a   (cur_eff),
		.b   (alu_b),
		.sum (alu_sum),
		.same(alu_same)
	);

	always_comb begin
		rec_take = 1'b0;
		mask_acc = '0;
		unique case (operation)
			rbpc_pkg::OP_SHADER: begin
				rec_take = pass_active_q;
				mask_acc[rbpc_pkg::C_SHD_REQ] = 1'b1;
				mask_acc[rbpc_pkg::C_SHD_CHG] = (object_id != last_program_q);
			end
			rbpc_pkg::OP_MATERIAL: begin
				rec_take = pass_active_q;
				mask_acc[rbpc_pkg::C_MAT_REQ] = 1'b1;
				mask_acc[rbpc_pkg::C_MAT_CHG] = (object_id != last_material_q);
			end
			rbpc_pkg::OP_DRAW, rbpc_pkg::OP_INSTANCED: begin
				rec_take = pass_active_q &&
					(operation == rbpc_pkg::OP_DRAW || instance_count != '0);
				mask_acc[rbpc_pkg::C_DRAW]      = 1'b1;
				mask_acc[rbpc_pkg::C_INST_DRAW] = (operation == rbpc_pkg::OP_INSTANCED);
				mask_acc[rbpc_pkg::C_INSTANCES] = 1'b1;
				mask_acc[rbpc_pkg::C_MESH_REQ]  = 1'b1;
				mask_acc[rbpc_pkg::C_MESH_CHG]  = (object_id != last_mesh_q);
			end
			rbpc_pkg::OP_TEXTURE: begin
				rec_take = pass_active_q;
				mask_acc[rbpc_pkg::C_TEX_REQ] = 1'b1;
				mask_acc[rbpc_pkg::C_TEX_CHG] = !unit_ok;
			end
			rbpc_pkg::OP_PLAIN_DRAW: begin
				rec_take = pass_active_q;
				mask_acc[rbpc_pkg::C_DRAW]      = 1'b1;
				mask_acc[rbpc_pkg::C_INSTANCES] = 1'b1;
			end
			default: begin
				rec_take = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		cur_ren    = 1'b0;
		snap_ren   = 1'b0;
		cur_raddr  = baddr_nxt;
		snap_raddr = rdaddr_in;
		unique case (state_q)
			rbpc_pkg::S_IDLE: begin
				if (in_valid) begin
					if (operation == rbpc_pkg::OP_FRAME_END) begin
						state_d = rbpc_pkg::S_SWEEP;
					end else if (rec_take && operation == rbpc_pkg::OP_TEXTURE && unit_ok) begin
						state_d = rbpc_pkg::S_TEX;
					end else if (rec_take) begin
						state_d = rbpc_pkg::S_BUMP_RD;
					end else if (operation == rbpc_pkg::OP_READ && ptype_ok && sel_ok) begin
						snap_ren = 1'b1;
						state_d  = rbpc_pkg::S_READ;
					end else begin
						state_d = rbpc_pkg::S_RESP;
					end
				end
			end
			rbpc_pkg::S_TEX: begin
				state_d = rbpc_pkg::S_BUMP_RD;
			end
			rbpc_pkg::S_BUMP_RD: begin
				cur_ren = 1'b1;
				state_d = rbpc_pkg::S_BUMP_WR;
			end
			rbpc_pkg::S_BUMP_WR: begin
				state_d = (mask_q != '0) ? rbpc_pkg::S_BUMP_RD : rbpc_pkg::S_RESP;
			end
			rbpc_pkg::S_SWEEP: begin
				cur_raddr  = sw_addr_q[AW-1:0];
				snap_raddr = sw_addr_q[AW-1:0];
				cur_ren    = sw_issue;
				snap_ren   = sw_issue;
				if (!sw_issue && !sw_v_s1) begin
					state_d = rbpc_pkg::S_RESP;
				end
			end
			rbpc_pkg::S_READ: begin
				state_d = rbpc_pkg::S_RESP;
			end
			rbpc_pkg::S_RESP: begin
				if (resp_go) begin
					state_d = rbpc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rbpc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbpc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= operation;
			id_q     <= object_id;
			icount_q <= instance_count;
			e_q      <= e_in;
			tex_rdata_s1 <= tex_mem[e_in];
		end
		if (cur_ren) begin
			cur_rdata_s1 <= cur_mem[cur_raddr];
		end
		if (snap_ren) begin
			snap_rdata_s1 <= snap_mem[snap_raddr];
		end
		if (state_q == rbpc_pkg::S_BUMP_WR) begin
			cur_mem[baddr_q] <= alu_sum;
		end
		if (sw_v_s1) begin
			snap_mem[sw_a_s1] <= cur_eff;
		end
		if (state_q == rbpc_pkg::S_TEX && tex_chg) begin
			tex_mem[e_q] <= id_q;
		end
		if (state_q == rbpc_pkg::S_BUMP_RD) begin
			baddr_q <= baddr_nxt;
		end
		sw_a_s1 <= sw_addr_q[AW-1:0];
		if (state_q == rbpc_pkg::S_RESP && resp_go) begin
			out_rd_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_active_q   <= 1'b0;
			active_pass_q   <= '0;
			last_program_q  <= '0;
			last_material_q <= '0;
			last_mesh_q     <= '0;
			tex_known_q     <= '0;
			cur_vld_q       <= '0;
			snap_vld_q      <= '0;
			snap_present_q  <= 1'b0;
			mask_q          <= '0;
			k_q             <= '0;
			diff_q          <= 1'b0;
			counted_q       <= 1'b0;
			rd_q            <= '0;
			sw_addr_q       <= '0;
			sw_v_s1         <= 1'b0;
			cur_rvld_s1     <= 1'b0;
			snap_rvld_s1    <= 1'b0;
			out_valid_q     <= 1'b0;
			out_diff_q      <= 1'b0;
			out_counted_q   <= 1'b0;
			out_snap_q      <= 1'b0;
		end else begin
			if (cur_ren) begin
				cur_rvld_s1 <= cur_vld_q[cur_raddr];
			end
			if (snap_ren) begin
				snap_rvld_s1 <= snap_vld_q[snap_raddr];
			end
			if (state_q == rbpc_pkg::S_RESP && resp_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				rbpc_pkg::S_IDLE: begin
					if (in_valid) begin
						rd_q      <= '0;
						diff_q    <= 1'b0;
						counted_q <= rec_take;
						sw_addr_q <= '0;
						if (rec_take) begin
							mask_q <= mask_acc;
						end
						unique case (operation)
							rbpc_pkg::OP_FRAME_START: begin
								cur_vld_q     <= '0;
								pass_active_q <= 1'b0;
							end
							rbpc_pkg::OP_PASS_START: begin
								if (ptype_ok) begin
									active_pass_q   <= pass_type;
									last_program_q  <= '0;
									last_material_q <= '0;
									last_mesh_q     <= '0;
									tex_known_q     <= '0;
									pass_active_q   <= 1'b1;
								end
							end
							rbpc_pkg::OP_PASS_END: begin
								pass_active_q <= 1'b0;
							end
							rbpc_pkg::OP_FRAME_END: begin
								diff_q <= !snap_present_q;
							end
							rbpc_pkg::OP_SHADER: begin
								if (rec_take) begin
									last_program_q <= object_id;
								end
							end
							rbpc_pkg::OP_MATERIAL: begin
								if (rec_take) begin
									last_material_q <= object_id;
								end
							end
							rbpc_pkg::OP_DRAW, rbpc_pkg::OP_INSTANCED: begin
								if (rec_take) begin
									last_mesh_q <= object_id;
								end
							end
							default: begin
							end
						endcase
					end
				end
				rbpc_pkg::S_TEX: begin
					if (tex_chg) begin
						tex_known_q[e_q]                <= 1'b1;
						mask_q[rbpc_pkg::C_TEX_CHG] <= 1'b1;
					end
				end
				rbpc_pkg::S_BUMP_RD: begin
					k_q            <= k_nxt;
					mask_q[k_nxt]  <= 1'b0;
				end
				rbpc_pkg::S_BUMP_WR: begin
					cur_vld_q[baddr_q] <= 1'b1;
				end
				rbpc_pkg::S_SWEEP: begin
					sw_v_s1 <= sw_issue;
					if (sw_issue) begin
						sw_addr_q <= sw_addr_q + SAW'(1);
					end
					if (sw_v_s1) begin
						snap_vld_q[sw_a_s1] <= 1'b1;
						if (!alu_same) begin
							diff_q <= 1'b1;
						end
					end
					if (!sw_issue && !sw_v_s1) begin
						snap_present_q <= 1'b1;
					end
				end
				rbpc_pkg::S_READ: begin
					rd_q <= snap_eff;
				end
				rbpc_pkg::S_RESP: begin
					if (resp_go) begin
						out_diff_q    <= diff_q;
						out_counted_q <= counted_q;
						out_snap_q    <= snap_present_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = out_rd_q;
	assign snapshot_valid = out_snap_q;
	assign frame_differed = out_diff_q;
	assign event_counted  = out_counted_q;

`ifndef SYNTHESIS
	a_bump_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rbpc_pkg::S_BUMP_RD |-> mask_q != '0)
		else $error("bump step with empty counter mask");

	a_diff_not_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_differed |-> !event_counted && snapshot_valid)
		else $error("frame difference flagged on a non frame-end beat");

	a_sweep_ends_present: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rbpc_pkg::S_SWEEP && state_d == rbpc_pkg::S_RESP |=> snap_present_q)
		else $error("snapshot not marked present after copy");

	a_read_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rbpc_pkg::S_READ |-> !counted_q && !diff_q)
		else $error("snapshot read carries event flags");
`endif

endmodule

// ===== bench/redundant_bind_perf_counters_chk.sv =====
`timescale 1ns / 1ps

module redundant_bind_perf_counters_chk #(
	parameter int PASSES        = 8,
	parameter int TEXTURE_UNITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [3:0]  operation,
	input  logic [2:0]  pass_type,
	input  logic [31:0] object_id,
	input  logic [7:0]  texture_unit,
	input  logic        is_cube_map,
	input  logic [23:0] instance_count,
	input  logic [3:0]  counter_select,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] read_value,
	input  logic        snapshot_valid,
	input  logic        frame_differed,
	input  logic        event_counted,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] rd;
		logic        snap;
		logic        diff;
		logic        counted;
	} beat_result_t;

	rbpc_pkg::cnt_t cur_cnt [PASSES*rbpc_pkg::NCNT];
	rbpc_pkg::cnt_t snap_cnt [PASSES*rbpc_pkg::NCNT];
	logic         have_snap;
	logic         in_pass;
	int           pass_idx;
	logic [31:0]  prev_prog, prev_mesh, prev_mat;
	logic         tex_seen [TEXTURE_UNITS*2];
	logic [31:0]  tex_bound [TEXTURE_UNITS*2];
	beat_result_t expected_q [$];

	function automatic void add_count(int which, longint amount);
		longint s;
		s = longint'(cur_cnt[pass_idx*rbpc_pkg::NCNT + which]) + amount;
		cur_cnt[pass_idx*rbpc_pkg::NCNT + which] =
			(s > 64'hFFFF_FFFF) ? '1 : rbpc_pkg::cnt_t'(s);
	endfunction

	function automatic void check_bind(int req, int chg, ref logic [31:0] prev,
		input logic [31:0] id);
		add_count(req, 1);
		if (prev != id) begin
			add_count(chg, 1);
			prev = id;
		end
	endfunction

	function automatic beat_result_t predict_counters(logic [3:0] op, logic [2:0] pt,
		logic [31:0] id, logic [7:0] unit, logic cube, logic [23:0] icnt, logic [3:0] sel);
		beat_result_t r;
		int e;
		logic differs;
		r = '0;
		differs = 1'b0;
		case (op)
			rbpc_pkg::OP_FRAME_START: begin
				foreach (cur_cnt[i]) cur_cnt[i] = '0;
				in_pass = 1'b0;
			end
			rbpc_pkg::OP_PASS_START: begin
				if (pt < PASSES) begin
					pass_idx = pt;
					prev_prog = '0;
					prev_mesh = '0;
					prev_mat = '0;
					foreach (tex_seen[i]) begin
						tex_seen[i] = 1'b0;
						tex_bound[i] = '0;
					end
					in_pass = 1'b1;
				end
			end
			rbpc_pkg::OP_PASS_END: in_pass = 1'b0;
			rbpc_pkg::OP_FRAME_END: begin
				foreach (cur_cnt[i]) begin
					if (cur_cnt[i] != snap_cnt[i]) differs = 1'b1;
				end
				if (!have_snap || differs) r.diff = 1'b1;
				foreach (cur_cnt[i]) snap_cnt[i] = cur_cnt[i];
				have_snap = 1'b1;
			end
			rbpc_pkg::OP_SHADER: if (in_pass) begin
				check_bind(rbpc_pkg::C_SHD_REQ, rbpc_pkg::C_SHD_CHG, prev_prog, id);
				r.counted = 1'b1;
			end
			rbpc_pkg::OP_MATERIAL: if (in_pass) begin
				check_bind(rbpc_pkg::C_MAT_REQ, rbpc_pkg::C_MAT_CHG, prev_mat, id);
				r.counted = 1'b1;
			end
			rbpc_pkg::OP_DRAW: if (in_pass) begin
				add_count(rbpc_pkg::C_DRAW, 1);
				add_count(rbpc_pkg::C_INSTANCES, 1);
				check_bind(rbpc_pkg::C_MESH_REQ, rbpc_pkg::C_MESH_CHG, prev_mesh, id);
				r.counted = 1'b1;
			end
			rbpc_pkg::OP_INSTANCED: if (in_pass && icnt != 0) begin
				add_count(rbpc_pkg::C_DRAW, 1);
				add_count(rbpc_pkg::C_INST_DRAW, 1);
				add_count(rbpc_pkg::C_INSTANCES, icnt);
				check_bind(rbpc_pkg::C_MESH_REQ, rbpc_pkg::C_MESH_CHG, prev_mesh, id);
				r.counted = 1'b1;
			end
			rbpc_pkg::OP_TEXTURE: if (in_pass) begin
				add_count(rbpc_pkg::C_TEX_REQ, 1);
				if (unit >= TEXTURE_UNITS) begin
					add_count(rbpc_pkg::C_TEX_CHG, 1);
				end else begin
					e = unit * 2 + cube;
					if (!tex_seen[e] || tex_bound[e] != id) begin
						add_count(rbpc_pkg::C_TEX_CHG, 1);
						tex_bound[e] = id;
						tex_seen[e] = 1'b1;
					end
				end
				r.counted = 1'b1;
			end
			rbpc_pkg::OP_PLAIN_DRAW: if (in_pass) begin
				add_count(rbpc_pkg::C_DRAW, 1);
				add_count(rbpc_pkg::C_INSTANCES, 1);
				r.counted = 1'b1;
			end
			rbpc_pkg::OP_READ: if (pt < PASSES && sel < rbpc_pkg::NCNT)
				r.rd = snap_cnt[pt*rbpc_pkg::NCNT + sel];
			default: ;
		endcase
		r.snap = have_snap;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		beat_result_t want;
		if (!arst_n) begin
			foreach (cur_cnt[i]) begin
				cur_cnt[i] = '0;
				snap_cnt[i] = '0;
			end
			foreach (tex_seen[i]) begin
				tex_seen[i] = 1'b0;
				tex_bound[i] = '0;
			end
			have_snap = 1'b0;
			in_pass = 1'b0;
			pass_idx = 0;
			prev_prog = '0;
			prev_mesh = '0;
			prev_mat = '0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected beat", read_value, 0);
				end else begin
					want = expected_q.pop_front();
					if (read_value !== want.rd)
						report_mismatch("read_value", read_value, want.rd);
					if (snapshot_valid !== want.snap)
						report_mismatch("snapshot_valid", snapshot_valid, want.snap);
					if (frame_differed !== want.diff)
						report_mismatch("frame_differed", frame_differed, want.diff);
					if (event_counted !== want.counted)
						report_mismatch("event_counted", event_counted, want.counted);
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(predict_counters(operation, pass_type, object_id,
					texture_unit, is_cube_map, instance_count, counter_select));
		end
	end

endmodule

// ===== bench/redundant_bind_perf_counters_tb.sv =====
`timescale 1ns / 1ps

module redundant_bind_perf_counters_tb;

	localparam int PASSES = 8;
	localparam int TEXTURE_UNITS = 16;
	localparam longint CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  operation = '0;
	logic [2:0]  pass_type = '0;
	logic [31:0] object_id = '0;
	logic [7:0]  texture_unit = '0;
	logic        is_cube_map = 1'b0;
	logic [23:0] instance_count = '0;
	logic [3:0]  counter_select = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [31:0] read_value;
	logic        snapshot_valid, frame_differed, event_counted;
	int          fail_count, pending;
	logic        hold_off = 1'b0;
	longint      cycles = 0;

	redundant_bind_perf_counters #(.PASSES(PASSES), .TEXTURE_UNITS(TEXTURE_UNITS)) uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .pass_type(pass_type), .object_id(object_id),
		.texture_unit(texture_unit), .is_cube_map(is_cube_map),
		.instance_count(instance_count), .counter_select(counter_select),
		.out_valid(out_valid), .out_stall(out_stall), .read_value(read_value),
		.snapshot_valid(snapshot_valid), .frame_differed(frame_differed),
		.event_counted(event_counted)
	);

	redundant_bind_perf_counters_chk #(.PASSES(PASSES), .TEXTURE_UNITS(TEXTURE_UNITS)) chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .pass_type(pass_type), .object_id(object_id),
		.texture_unit(texture_unit), .is_cube_map(is_cube_map),
		.instance_count(instance_count), .counter_select(counter_select),
		.out_valid(out_valid), .out_stall(out_stall), .read_value(read_value),
		.snapshot_valid(snapshot_valid), .frame_differed(frame_differed),
		.event_counted(event_counted), .fail_count(fail_count), .pending(pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("redundant_bind_perf_counters test failed");
			$finish;
		end
	end

	// receiver: random stall per beat, plus a long hold-off on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else begin
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
				if (cycles % 4000 < 1000) w = 0;
				if (w > 0) begin
					out_stall <= 1'b1;
					repeat (w - 1) @(negedge clk);
					@(negedge clk);
				end
				out_stall <= 1'b0;
				do @(posedge clk); while (!out_valid);
			end
		end
	end

	task automatic send_beat(logic [3:0] op, logic [2:0] pt, logic [31:0] id,
		logic [7:0] unit, logic cube, logic [23:0] icnt, logic [3:0] sel, bit no_gap = 0);
		int g;
		g = no_gap ? 0 : $urandom_range(0, 13);
		if ($urandom_range(0, 2) == 0) g = 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pass_type <= pt;
		object_id <= id;
		texture_unit <= unit;
		is_cube_map <= cube;
		instance_count <= icnt;
		counter_select <= sel;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_beat(int passes_w);
		logic [3:0] op;
		logic [31:0] id;
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) op = rbpc_pkg::OP_FRAME_START;
		else if (r < 9) op = rbpc_pkg::OP_PASS_START;
		else if (r < 12) op = rbpc_pkg::OP_PASS_END;
		else if (r < 15) op = rbpc_pkg::OP_FRAME_END;
		else if (r < 85) op = 4'($urandom_range(4, 9));
		else if (r < 97) op = rbpc_pkg::OP_READ;
		else op = 4'($urandom_range(11, 15));
		id = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
		send_beat(op, 3'($urandom_range(0, passes_w)), id,
			($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
			1'($urandom), ($urandom_range(0, 9) == 0) ? 24'($urandom) :
			24'($urandom_range(0, 4)), 4'($urandom_range(0, 15)));
	endtask

	initial begin
		int n;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed
		send_beat(rbpc_pkg::OP_SHADER, '0, 32'h5, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_FRAME_END, '0, '0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_FRAME_END, '0, '0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_PASS_START, 3'd7, '0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_SHADER, '0, 32'hFFFF_FFFF, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_SHADER, '0, 32'hFFFF_FFFF, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_MATERIAL, '0, 32'h0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_DRAW, '0, 32'h1, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_INSTANCED, '0, 32'h1, '0, 1'b0, 24'hFFFFFF, '0);
		send_beat(rbpc_pkg::OP_INSTANCED, '0, 32'h2, '0, 1'b0, 24'h0, '0);
		send_beat(rbpc_pkg::OP_TEXTURE, '0, 32'h0, 8'd0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_TEXTURE, '0, 32'h0, 8'd0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_TEXTURE, '0, 32'h0, 8'd15, 1'b1, '0, '0);
		send_beat(rbpc_pkg::OP_TEXTURE, '0, 32'h9, 8'd255, 1'b1, '0, '0);
		send_beat(rbpc_pkg::OP_PLAIN_DRAW, '0, '0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_PASS_END, '0, '0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_PLAIN_DRAW, '0, '0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_FRAME_END, '0, '0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_READ, 3'd7, '0, '0, 1'b0, '0, 4'd2);
		send_beat(rbpc_pkg::OP_READ, 3'd7, '0, '0, 1'b0, '0, 4'd10);
		send_beat(rbpc_pkg::OP_READ, 3'd7, '0, '0, 1'b0, '0, 4'd15);
		send_beat(4'd15, 3'd7, 32'hFFFF_FFFF, 8'hFF, 1'b1, 24'hFFFFFF, 4'hF);
		send_beat(rbpc_pkg::OP_FRAME_START, '0, '0, '0, 1'b0, '0, '0);

		// saturate the instance counter of one pass
		send_beat(rbpc_pkg::OP_PASS_START, 3'd2, '0, '0, 1'b0, '0, '0);
		repeat (260) send_beat(rbpc_pkg::OP_INSTANCED, '0, $urandom, '0, 1'b0,
			24'hFFFFFF, '0, 1);
		send_beat(rbpc_pkg::OP_FRAME_END, '0, '0, '0, 1'b0, '0, '0);
		send_beat(rbpc_pkg::OP_READ, 3'd2, '0, '0, 1'b0, '0, 4'(rbpc_pkg::C_INSTANCES));
		in_valid <= 1'b0;

		// sender pauses until drained
		wait (pending == 0);

		// receiver holds off while the sender keeps offering
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (20) send_random_beat(7);
		join

		n = 0;
		while (n < 800) begin
			send_random_beat(7);
			n++;
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (200) @(negedge clk);
		if (fail_count == 0) begin
			$display("redundant_bind_perf_counters test passed");
		end else begin
			$display("redundant_bind_perf_counters test failed");
		end
		$finish;
	end

endmodule
